@@ sv/spq_pkg.sv @@
// Shared types and constants for the sorted shift-register priority queue.
// No dependencies; used by spq_cell and sorted_array_priority_queue_core.
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 128;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int TAG_BITS_DEF      = 16;
    localparam int COUNT_OUT_BITS    = 8;

    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_spq_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_spq_status;

    // Broadcast to every cell in the chain for one word.
    typedef struct packed {
        logic ins;   // accepted enqueue into a non-full queue
        logic pop;   // accepted dequeue from a non-empty queue
    } t_spq_ctrl;

endpackage

@@ sv/spq_cell.sv @@
// One slot of the priority queue chain. Cell 0 holds the top entry.
// Depends on spq_pkg (t_spq_ctrl).
module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
    input  logic                     i_clk,
    input  spq_pkg::t_spq_ctrl       i_ctrl,
    input  logic [PRIORITY_BITS-1:0] i_new_prio,
    input  logic [TAG_BITS-1:0]      i_new_tag,
    input  logic                     i_occupied,
    input  logic                     i_left_gt,
    input  logic [PRIORITY_BITS-1:0] i_left_prio,
    input  logic [TAG_BITS-1:0]      i_left_tag,
    input  logic [PRIORITY_BITS-1:0] i_right_prio,
    input  logic [TAG_BITS-1:0]      i_right_tag,
    output logic                     o_gt,
    output logic [PRIORITY_BITS-1:0] o_prio,
    output logic [TAG_BITS-1:0]      o_tag
);

    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic [TAG_BITS-1:0]      r_tag,  n_tag;

    // Entry stays put on insert only if it outranks the new one.
    assign o_gt = i_occupied && (r_prio > i_new_prio);

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        priority if (i_ctrl.pop) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end else if (i_ctrl.ins && !o_gt) begin
            if (i_left_gt) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end else begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;

endmodule

@@ sv/sorted_array_priority_queue_core.sv @@
// Sorted shift-register priority queue: a chain of QUEUE_DEPTH cells, top entry in cell 0.
// o_done rises in the cycle after start; throughput one word per cycle, busy never rises,
// since every cell shifts or inserts in parallel in the same clock.
// Synchronous active-low reset clears the entry count and strobe; slot contents are not reset.
// The receiver cannot stall; each result stays on the ports until the next accepted word.
// Depends on spq_pkg and spq_cell.
module sorted_array_priority_queue_core #(
    parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic [PRIORITY_BITS-1:0]           i_priority_req,
    input  logic [TAG_BITS-1:0]                i_tag,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [PRIORITY_BITS-1:0]           o_out_priority,
    output logic [TAG_BITS-1:0]                o_out_tag,
    output logic [spq_pkg::COUNT_OUT_BITS-1:0] o_entry_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int OB = spq_pkg::COUNT_OUT_BITS;

    logic                     w_accept, w_full, w_empty;
    spq_pkg::t_spq_ctrl       w_ctrl;
    logic [CW-1:0]            r_count, n_count;

    logic                     w_gt      [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio    [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      w_tag     [QUEUE_DEPTH];
    logic                     w_occ     [QUEUE_DEPTH];

    logic                     r_done;
    spq_pkg::t_spq_status     r_status, n_status;
    logic [PRIORITY_BITS-1:0] r_out_prio, n_out_prio;
    logic [TAG_BITS-1:0]      r_out_tag,  n_out_tag;
    logic [OB-1:0]            r_entry_count;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctrl.ins = w_accept && (i_opcode == spq_pkg::OP_ENQUEUE) && !w_full;
    assign w_ctrl.pop = w_accept && (i_opcode == spq_pkg::OP_DEQUEUE) && !w_empty;

    always_comb begin
        n_count = r_count;
        priority if (w_ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_status   = spq_pkg::ST_OK;
        n_out_prio = '0;
        n_out_tag  = '0;
        unique case (i_opcode)
            spq_pkg::OP_ENQUEUE: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_OVERFLOW;
                end
            end
            spq_pkg::OP_DEQUEUE: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_UNDERFLOW;
                end else begin
                    n_out_prio = w_prio[0];
                    n_out_tag  = w_tag[0];
                end
            end
            default: n_status = spq_pkg::ST_OK;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                     w_lgt;
            logic [PRIORITY_BITS-1:0] w_lprio, w_rprio;
            logic [TAG_BITS-1:0]      w_ltag,  w_rtag;

            assign w_occ[gi] = (r_count > CW'(gi));

            if (gi == 0) begin : g_head
                assign w_lgt   = 1'b1;
                assign w_lprio = i_priority_req;
                assign w_ltag  = i_tag;
            end else begin : g_body
                assign w_lgt   = w_gt[gi-1];
                assign w_lprio = w_prio[gi-1];
                assign w_ltag  = w_tag[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign w_rprio = w_prio[gi];
                assign w_rtag  = w_tag[gi];
            end else begin : g_inner
                assign w_rprio = w_prio[gi+1];
                assign w_rtag  = w_tag[gi+1];
            end

            spq_cell #(
                .PRIORITY_BITS(PRIORITY_BITS),
                .TAG_BITS     (TAG_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_new_prio  (i_priority_req),
                .i_new_tag   (i_tag),
                .i_occupied  (w_occ[gi]),
                .i_left_gt   (w_lgt),
                .i_left_prio (w_lprio),
                .i_left_tag  (w_ltag),
                .i_right_prio(w_rprio),
                .i_right_tag (w_rtag),
                .o_gt        (w_gt[gi]),
                .o_prio      (w_prio[gi]),
                .o_tag       (w_tag[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    // entry count is reported masked to the output width
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_out_prio    <= n_out_prio;
            r_out_tag     <= n_out_tag;
            r_entry_count <= OB'(n_count);
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_out_priority = r_out_prio;
    assign o_out_tag      = r_out_tag;
    assign o_entry_count  = r_entry_count;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("result strobe missing after accepted word");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == spq_pkg::ST_UNDERFLOW) |->
            (o_out_priority == '0 && o_out_tag == '0))
        else $error("underflow result carries data");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && i_opcode == spq_pkg::OP_ENQUEUE) |=> (r_count == $past(r_count)))
        else $error("overflowing enqueue changed the count");

endmodule
